FILE: design/gkem_pkg.sv
// shared types, constants and microcode table of the gamepad key event mapper
package gkem_pkg;

	// number of controller slots with tracked state
	localparam int USER_COUNT = 4;
	localparam int USER_W = 3;
	localparam int UIDX_W = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;

	// virtual buttons: 16 digital buttons and two triggers
	localparam int VBUTTONS = 18;
	localparam int VB_W = 5;
	localparam logic [VB_W-1:0] VB_LEFT_TRIG = VB_W'(16);
	localparam logic [VB_W-1:0] VB_RIGHT_TRIG = VB_W'(17);
	localparam logic [VB_W-1:0] VB_LAST = VB_W'(VBUTTONS - 1);

	localparam int KEY_W = 8;
	localparam int CODES_PER_REG = 6;
	localparam int KC_REG_W = KEY_W * CODES_PER_REG;
	localparam int CFG_DATA_W = KC_REG_W;
	localparam logic [7:0] THRESHOLD_RESET = 8'd30;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_KEY_CODES_LOW = 3'd0,
		REG_KEY_CODES_MID = 3'd1,
		REG_KEY_CODES_HIGH = 3'd2,
		REG_CTRL_MASK = 3'd3,
		REG_SHIFT_MASK = 3'd4,
		REG_ALT_MASK = 3'd5,
		REG_TRIGGER_THRESHOLD = 3'd6
	} cfg_reg_t;

	// result kinds
	localparam logic KIND_KEY_EVENT = 1'b0;
	localparam logic KIND_POLL = 1'b1;

	// configuration seen by the datapath
	typedef struct packed {
		logic [KC_REG_W-1:0] key_codes_high;
		logic [KC_REG_W-1:0] key_codes_mid;
		logic [KC_REG_W-1:0] key_codes_low;
		logic [VBUTTONS-1:0] ctrl_mask;
		logic [VBUTTONS-1:0] shift_mask;
		logic [VBUTTONS-1:0] alt_mask;
		logic [7:0] trigger_threshold;
	} cfg_t;

	// microprogram steps
	typedef logic [1:0] step_t;
	localparam step_t STEP_LOAD = 2'd0;
	localparam step_t STEP_SCAN = 2'd1;
	localparam step_t STEP_FINAL = 2'd2;

	// sequencer jump kinds
	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_GOTO,
		JMP_BR_OOR,
		JMP_LOOP
	} jump_t;

	// one control word
	typedef struct packed {
		logic accept;
		logic scan;
		logic emit_final;
		jump_t jmp;
		step_t target;
	} uword_t;

	// datapath controls driven by the sequencer
	typedef struct packed {
		logic accept;
		logic scan;
		logic emit_final;
	} ctrl_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic hold;
		logic oor;
		logic scan_last;
	} status_t;

	// control store
	function automatic uword_t uc_rom(input step_t step);
		uword_t w;
		w = '0;
		case (step)
			// wait for a poll, skip the scan for an untracked user
			STEP_LOAD: begin
				w.accept = 1'b1;
				w.jmp = JMP_BR_OOR;
				w.target = STEP_FINAL;
			end
			// one virtual button per step
			STEP_SCAN: begin
				w.scan = 1'b1;
				w.jmp = JMP_LOOP;
				w.target = STEP_SCAN;
			end
			// filtered poll, state update
			STEP_FINAL: begin
				w.emit_final = 1'b1;
				w.jmp = JMP_GOTO;
				w.target = STEP_LOAD;
			end
			default: begin
				w.jmp = JMP_GOTO;
				w.target = STEP_LOAD;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: design/gkem_useq.sv
// microcode sequencer: step counter, control store and jump logic
module gkem_useq (
	input logic clk,
	input logic arst_n,
	input gkem_pkg::status_t status,
	output gkem_pkg::ctrl_t ctrl
);
	import gkem_pkg::*;

	step_t step_q;
	step_t step_next;
	uword_t uw;

	assign uw = uc_rom(step_q);
	assign ctrl.accept = uw.accept;
	assign ctrl.scan = uw.scan;
	assign ctrl.emit_final = uw.emit_final;

	// next step selection
	always_comb begin
		step_next = step_q;
		if (!status.hold) begin
			unique case (uw.jmp)
				JMP_NEXT: step_next = step_q + step_t'(1);
				JMP_GOTO: step_next = uw.target;
				JMP_BR_OOR: step_next = status.oor ? uw.target : step_q + step_t'(1);
				JMP_LOOP: step_next = status.scan_last ? step_q + step_t'(1) : uw.target;
				default: step_next = STEP_LOAD;
			endcase
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_LOAD;
		end else begin
			step_q <= step_next;
		end
	end

	// the store never leaves its three steps
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == STEP_LOAD || step_q == STEP_SCAN || step_q == STEP_FINAL)
		else $error("sequencer left its program");
	// a scan step finishing on the last button moves to the final step
	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == STEP_SCAN && status.scan_last && !status.hold |=> step_q == STEP_FINAL)
		else $error("scan did not end in final step");
	// an untracked user skips the scan
	a_oor_skip: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == STEP_LOAD && !status.hold && status.oor |=> step_q == STEP_FINAL)
		else $error("out of range user entered scan");

endmodule

FILE: design/gkem_dpath.sv
// datapath: poll registers, per-user button state, button scan and result register
module gkem_dpath (
	input logic clk,
	input logic arst_n,
	input gkem_pkg::cfg_t cfg,
	input gkem_pkg::ctrl_t ctrl,
	output gkem_pkg::status_t status,
	input logic in_valid,
	output logic in_ready,
	input logic [gkem_pkg::USER_W-1:0] in_user,
	input logic [15:0] in_buttons,
	input logic [7:0] in_left,
	input logic [7:0] in_right,
	output logic out_valid,
	input logic out_ready,
	output logic out_kind,
	output logic [gkem_pkg::KEY_W-1:0] out_code,
	output logic out_up,
	output logic out_ctrl,
	output logic out_shift,
	output logic out_alt,
	output logic [15:0] out_buttons,
	output logic [7:0] out_left,
	output logic [7:0] out_right,
	output logic out_last
);
	import gkem_pkg::*;

	logic [VBUTTONS-1:0] prev_q [USER_COUNT];
	logic [USER_W-1:0] user_q;
	logic oor_q;
	logic [15:0] btn_q;
	logic [7:0] lt_q;
	logic [7:0] rt_q;
	logic [VBUTTONS-1:0] cur_q;
	logic [VBUTTONS-1:0] chg_q;
	logic [VB_W-1:0] idx_q;

	logic [KEY_W-1:0] codes [VBUTTONS];
	logic [KEY_W-1:0] code_sel;
	logic mapped;
	logic hit;
	logic out_free;
	logic in_take;
	logic in_oor;
	logic [VBUTTONS-1:0] in_cur;
	logic scan_fire;
	logic final_fire;
	logic out_load;

	// key code table unpacked from the three code registers
	always_comb begin
		for (int b = 0; b < CODES_PER_REG; b++) begin
			codes[b] = cfg.key_codes_low[b*KEY_W +: KEY_W];
			codes[b + CODES_PER_REG] = cfg.key_codes_mid[b*KEY_W +: KEY_W];
			codes[b + 2*CODES_PER_REG] = cfg.key_codes_high[b*KEY_W +: KEY_W];
		end
	end

	// current button under scan
	assign code_sel = codes[idx_q];
	assign mapped = (code_sel != '0);
	assign hit = mapped && chg_q[idx_q];

	// incoming poll as a virtual map
	assign in_oor = ({1'b0, in_user} >= (USER_W+1)'(USER_COUNT));
	assign in_cur = {in_right > cfg.trigger_threshold, in_left > cfg.trigger_threshold,
		in_buttons};

	// handshake and stall decisions
	assign out_free = !out_valid || out_ready;
	assign in_ready = ctrl.accept;
	assign in_take = ctrl.accept && in_valid;
	assign scan_fire = ctrl.scan && (!hit || out_free);
	assign final_fire = ctrl.emit_final && out_free;
	assign out_load = (scan_fire && hit) || final_fire;

	always_comb begin
		status.hold = (ctrl.accept && !in_valid) || (ctrl.scan && hit && !out_free)
			|| (ctrl.emit_final && !out_free);
		status.oor = in_oor;
		status.scan_last = (idx_q == VB_LAST);
	end

	// poll registers and scan index
	always_ff @(posedge clk) begin
		if (in_take) begin
			user_q <= in_user;
			oor_q <= in_oor;
			btn_q <= in_buttons;
			lt_q <= in_left;
			rt_q <= in_right;
			cur_q <= in_cur;
			chg_q <= in_cur ^ prev_q[in_user[UIDX_W-1:0]];
			idx_q <= '0;
		end else if (scan_fire) begin
			idx_q <= idx_q + VB_W'(1);
			if (mapped) begin
				if (idx_q == VB_LEFT_TRIG) begin
					lt_q <= '0;
				end else if (idx_q == VB_RIGHT_TRIG) begin
					rt_q <= '0;
				end else begin
					btn_q[idx_q[3:0]] <= 1'b0;
				end
			end
		end
	end

	// per-user previous virtual map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int u = 0; u < USER_COUNT; u++) begin
				prev_q[u] <= '0;
			end
		end else if (final_fire && !oor_q) begin
			prev_q[user_q[UIDX_W-1:0]] <= cur_q;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (final_fire) begin
				out_kind <= KIND_POLL;
				out_code <= '0;
				out_up <= 1'b0;
				out_ctrl <= 1'b0;
				out_shift <= 1'b0;
				out_alt <= 1'b0;
				out_buttons <= btn_q;
				out_left <= lt_q;
				out_right <= rt_q;
				out_last <= 1'b1;
			end else begin
				out_kind <= KIND_KEY_EVENT;
				out_code <= code_sel;
				out_up <= !cur_q[idx_q];
				out_ctrl <= cfg.ctrl_mask[idx_q];
				out_shift <= cfg.shift_mask[idx_q];
				out_alt <= cfg.alt_mask[idx_q];
				out_buttons <= '0;
				out_left <= '0;
				out_right <= '0;
				out_last <= 1'b0;
			end
		end
	end

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten");
	// the scan index stays on a virtual button
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.scan |-> idx_q <= VB_LAST)
		else $error("scan index out of range");
	// the filtered poll closes the transaction group
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		final_fire |=> out_valid && out_last && out_kind == KIND_POLL)
		else $error("final result not marked last");

endmodule

FILE: design/gamepad_to_key_event_mapper_top.sv
// top level of the gamepad key event mapper: ports, configuration registers, sequencer and datapath
//
// Each accepted poll runs one load step, one scan step for each of the 18 virtual buttons and
// one step for the filtered poll result; a poll from an untracked user skips the scan steps.
// The microcode sequencer runs one step per cycle while it is not held: the load step waits
// for a poll, and a step that has to emit a result waits while the single result register is
// still full, so back-pressure on the master side stalls the sequencer. A poll yields up to 18
// key event transactions followed by the filtered poll transaction, which carries tlast.
// No new poll is taken until the final result of the previous one is in the result register.
module gamepad_to_key_event_mapper_top (
	input logic clk,
	input logic arst_n,
	// configuration write port
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [gkem_pkg::CFG_DATA_W-1:0] cfg_data,
	// poll input
	input logic s_tvalid,
	output logic s_tready,
	// user_number[2:0], buttons_in[18:3], left_trigger_in[26:19], right_trigger_in[34:27]
	input logic [39:0] s_tdata,
	// result output
	output logic m_tvalid,
	input logic m_tready,
	// key_code[7:0], key_up[8], with_ctrl[9], with_shift[10], with_alt[11],
	// buttons_out[27:12], left_trigger_out[35:28], right_trigger_out[43:36]
	output logic [47:0] m_tdata,
	// result_kind[0]
	output logic m_tuser,
	output logic m_tlast
);
	import gkem_pkg::*;

	cfg_t cfg_q;
	ctrl_t ctrl;
	status_t status;

	logic out_kind;
	logic [KEY_W-1:0] out_code;
	logic out_up;
	logic out_ctrl;
	logic out_shift;
	logic out_alt;
	logic [15:0] out_buttons;
	logic [7:0] out_left;
	logic [7:0] out_right;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_codes_low <= '0;
			cfg_q.key_codes_mid <= '0;
			cfg_q.key_codes_high <= '0;
			cfg_q.ctrl_mask <= '0;
			cfg_q.shift_mask <= '0;
			cfg_q.alt_mask <= '0;
			cfg_q.trigger_threshold <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_CODES_LOW: cfg_q.key_codes_low <= cfg_data;
				REG_KEY_CODES_MID: cfg_q.key_codes_mid <= cfg_data;
				REG_KEY_CODES_HIGH: cfg_q.key_codes_high <= cfg_data;
				REG_CTRL_MASK: cfg_q.ctrl_mask <= cfg_data[VBUTTONS-1:0];
				REG_SHIFT_MASK: cfg_q.shift_mask <= cfg_data[VBUTTONS-1:0];
				REG_ALT_MASK: cfg_q.alt_mask <= cfg_data[VBUTTONS-1:0];
				REG_TRIGGER_THRESHOLD: cfg_q.trigger_threshold <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// microprogram control
	gkem_useq u_useq (
		.clk(clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl(ctrl)
	);

	// datapath
	gkem_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.ctrl(ctrl),
		.status(status),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_user(s_tdata[2:0]),
		.in_buttons(s_tdata[18:3]),
		.in_left(s_tdata[26:19]),
		.in_right(s_tdata[34:27]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind(out_kind),
		.out_code(out_code),
		.out_up(out_up),
		.out_ctrl(out_ctrl),
		.out_shift(out_shift),
		.out_alt(out_alt),
		.out_buttons(out_buttons),
		.out_left(out_left),
		.out_right(out_right),
		.out_last(m_tlast)
	);

	// output packing
	assign m_tdata = {4'b0000, out_right, out_left, out_buttons, out_alt, out_shift, out_ctrl,
		out_up, out_code};
	assign m_tuser = out_kind;

endmodule

FILE: sim/gkem_checker.sv
// checker for the gamepad key event mapper: predicts every result from the polls and compares
`timescale 1ns / 100ps
module gkem_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [gkem_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic s_tvalid,
	input logic s_tready,
	input logic [39:0] s_tdata,
	input logic m_tvalid,
	input logic m_tready,
	input logic [47:0] m_tdata,
	input logic m_tuser,
	input logic m_tlast,
	output int fail_count,
	output int pending,
	output int poll_count,
	output int result_count,
	output int key_event_count
);
	import gkem_pkg::*;

	// one result transaction, unpacked
	typedef struct packed {
		logic kind;
		logic [KEY_W-1:0] key_code;
		logic key_up;
		logic with_ctrl;
		logic with_shift;
		logic with_alt;
		logic [15:0] buttons;
		logic [7:0] left_trig;
		logic [7:0] right_trig;
		logic is_last;
	} key_result_t;

	key_result_t expected_results[$];

	// shadow copy of the configuration and the per-user button maps
	logic [KC_REG_W-1:0] key_codes [3];
	logic [VBUTTONS-1:0] ctrl_bits;
	logic [VBUTTONS-1:0] shift_bits;
	logic [VBUTTONS-1:0] alt_bits;
	logic [7:0] threshold;
	logic [VBUTTONS-1:0] prev_map [USER_COUNT];
	int reported;

	function automatic string show(input key_result_t r);
		return $sformatf("kind %0d code %02h up %0d csa %0d%0d%0d btn %04h lt %02h rt %02h last %0d",
			r.kind, r.key_code, r.key_up, r.with_ctrl, r.with_shift, r.with_alt,
			r.buttons, r.left_trig, r.right_trig, r.is_last);
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (reported < 10) begin
			reported++;
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	// expected results of one poll, key events in button order, then the filtered poll
	task automatic predict_poll(input logic [USER_W-1:0] user, input logic [15:0] btn,
			input logic [7:0] lt, input logic [7:0] rt);
		logic [VBUTTONS-1:0] cur_map;
		logic [VBUTTONS-1:0] changed;
		logic [KEY_W-1:0] code;
		key_result_t r;
		if (user < USER_COUNT) begin
			cur_map = {rt > threshold, lt > threshold, btn};
			changed = cur_map ^ prev_map[user];
			for (int b = 0; b < VBUTTONS; b++) begin
				code = key_codes[b / CODES_PER_REG][(b % CODES_PER_REG) * KEY_W +: KEY_W];
				if (code != '0) begin
					if (changed[b]) begin
						r = '0;
						r.kind = KIND_KEY_EVENT;
						r.key_code = code;
						r.key_up = ~cur_map[b];
						r.with_ctrl = ctrl_bits[b];
						r.with_shift = shift_bits[b];
						r.with_alt = alt_bits[b];
						expected_results.push_back(r);
					end
					// mapped inputs are hidden from the filtered poll
					if (b < VB_LEFT_TRIG)
						btn[b] = 1'b0;
					else if (b == VB_LEFT_TRIG)
						lt = '0;
					else
						rt = '0;
				end
			end
			prev_map[user] = cur_map;
		end
		r = '0;
		r.kind = KIND_POLL;
		r.buttons = btn;
		r.left_trig = lt;
		r.right_trig = rt;
		r.is_last = 1'b1;
		expected_results.push_back(r);
	endtask

	task automatic check_result(input key_result_t got);
		key_result_t want;
		result_count++;
		if (got.kind == KIND_KEY_EVENT)
			key_event_count++;
		if (expected_results.size() == 0) begin
			note_failure({"unexpected result ", show(got)});
		end else begin
			want = expected_results.pop_front();
			if (got.kind !== want.kind || got.key_code !== want.key_code ||
					got.key_up !== want.key_up || got.with_ctrl !== want.with_ctrl ||
					got.with_shift !== want.with_shift || got.with_alt !== want.with_alt ||
					got.buttons !== want.buttons || got.left_trig !== want.left_trig ||
					got.right_trig !== want.right_trig || got.is_last !== want.is_last)
				note_failure({"expected ", show(want), " got ", show(got)});
		end
	endtask

	// watch both streams and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_codes[0] = '0;
			key_codes[1] = '0;
			key_codes[2] = '0;
			ctrl_bits = '0;
			shift_bits = '0;
			alt_bits = '0;
			threshold = THRESHOLD_RESET;
			for (int u = 0; u < USER_COUNT; u++)
				prev_map[u] = '0;
			expected_results.delete();
			fail_count = 0;
			reported = 0;
			poll_count = 0;
			result_count = 0;
			key_event_count = 0;
		end else begin
			// result transaction
			if (m_tvalid && m_tready)
				check_result({m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[10],
					m_tdata[11], m_tdata[27:12], m_tdata[35:28], m_tdata[43:36], m_tlast});
			// poll transaction
			if (s_tvalid && s_tready) begin
				poll_count++;
				predict_poll(s_tdata[2:0], s_tdata[18:3], s_tdata[26:19], s_tdata[34:27]);
			end
			// register write
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_KEY_CODES_LOW: key_codes[0] = cfg_data[KC_REG_W-1:0];
					REG_KEY_CODES_MID: key_codes[1] = cfg_data[KC_REG_W-1:0];
					REG_KEY_CODES_HIGH: key_codes[2] = cfg_data[KC_REG_W-1:0];
					REG_CTRL_MASK: ctrl_bits = cfg_data[VBUTTONS-1:0];
					REG_SHIFT_MASK: shift_bits = cfg_data[VBUTTONS-1:0];
					REG_ALT_MASK: alt_bits = cfg_data[VBUTTONS-1:0];
					REG_TRIGGER_THRESHOLD: threshold = cfg_data[7:0];
					default: ;
				endcase
			end
		end
		pending = expected_results.size();
	end

endmodule

FILE: sim/tb_gamepad_to_key_event_mapper_top.sv
// testbench top for the gamepad key event mapper: clock, reset, stimulus, pacing and verdict
`timescale 1ns / 100ps
module tb_gamepad_to_key_event_mapper_top;
	import gkem_pkg::*;

	localparam int STALL_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_POLLS = 152;
	// index past the last register, must be ignored
	localparam logic [2:0] REG_NONE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	int fail_count;
	int pending;
	int poll_count;
	int result_count;
	int key_event_count;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles = 0;
	bit stall_request = 1'b0;
	logic [7:0] threshold_now = THRESHOLD_RESET;
	logic [15:0] last_buttons [8] = '{default: '0};

	gamepad_to_key_event_mapper_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	gkem_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.pending(pending),
		.poll_count(poll_count),
		.result_count(result_count),
		.key_event_count(key_event_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random back-pressure, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				for (int n = 0; n < STALL_CYCLES; n++) begin
					m_tready = 1'b0;
					@(negedge clk);
				end
			end
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one poll and hold it until the block takes it
	task automatic send_poll(input logic [2:0] user, input logic [15:0] btn,
			input logic [7:0] lt, input logic [7:0] rt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {5'b0, rt, lt, btn, user};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		last_buttons[user] = btn;
	endtask

	// stop offering and wait for every expected result
	task automatic end_stream();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [CFG_DATA_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		@(negedge clk);
	endtask

	task automatic load_config(input logic [KC_REG_W-1:0] codes_lo,
			input logic [KC_REG_W-1:0] codes_mid, input logic [KC_REG_W-1:0] codes_hi,
			input logic [VBUTTONS-1:0] ctrl, input logic [VBUTTONS-1:0] shift,
			input logic [VBUTTONS-1:0] alt, input logic [7:0] thr);
		write_reg(REG_KEY_CODES_LOW, codes_lo);
		write_reg(REG_KEY_CODES_MID, codes_mid);
		write_reg(REG_KEY_CODES_HIGH, codes_hi);
		write_reg(REG_CTRL_MASK, CFG_DATA_W'(ctrl));
		write_reg(REG_SHIFT_MASK, CFG_DATA_W'(shift));
		write_reg(REG_ALT_MASK, CFG_DATA_W'(alt));
		write_reg(REG_TRIGGER_THRESHOLD, CFG_DATA_W'(thr));
		cfg_we = 1'b0;
		threshold_now = thr;
	endtask

	// six key codes, about a quarter of them unmapped
	function automatic logic [KC_REG_W-1:0] rand_codes();
		logic [KC_REG_W-1:0] v;
		for (int j = 0; j < CODES_PER_REG; j++)
			v[j*KEY_W +: KEY_W] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
		return v;
	endfunction

	// trigger values clustered around the threshold
	function automatic logic [7:0] pick_trigger();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return threshold_now;
			3: return threshold_now + 8'd1;
			default: return 8'($urandom);
		endcase
	endfunction

	// random polls: mostly tracked users, with small button changes as the most common case
	task automatic run_random_phase(input int polls, input int stall_at);
		logic [2:0] user;
		logic [15:0] btn;
		for (int n = 0; n < polls; n++) begin
			if (n == stall_at)
				stall_request = 1'b1;
			if ($urandom_range(99) < 85)
				user = 3'($urandom_range(USER_COUNT - 1));
			else
				user = 3'($urandom_range(7, USER_COUNT));
			case ($urandom_range(9)) inside
				0, 1, 2: btn = 16'($urandom);
				3, 4, 5, 6: begin
					btn = last_buttons[user] ^ (16'h1 << $urandom_range(15));
					if ($urandom_range(1) == 1)
						btn = btn ^ (16'h1 << $urandom_range(15));
				end
				7: btn = last_buttons[user];
				8: btn = 16'h0000;
				default: btn = 16'hFFFF;
			endcase
			send_poll(user, btn, pick_trigger(), pick_trigger());
		end
		end_stream();
	endtask

	// stimulus and verdict
	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset configuration: nothing mapped, everything passes through
		send_poll(3'd0, 16'hFFFF, 8'hFF, 8'hFF);
		send_poll(3'd1, 16'h0000, 8'h00, 8'h00);
		end_stream();
		write_reg(REG_NONE, '1);
		cfg_we = 1'b0;
		send_poll(3'd0, 16'hFFFF, 8'd31, 8'd30);
		end_stream();

		// every button mapped to the top code, threshold at zero
		load_config('1, '1, '1, '1, '0, 18'h2AAAA, 8'd0);
		send_poll(3'd0, 16'h0000, 8'h00, 8'h00);
		send_poll(3'd0, 16'hFFFF, 8'h01, 8'h01);
		send_poll(3'd0, 16'hFFFF, 8'h01, 8'h01);
		send_poll(3'd7, 16'hFFFF, 8'hFF, 8'hFF);
		send_poll(3'd4, 16'h1234, 8'h80, 8'h80);
		send_poll(3'd3, 16'hA5A5, 8'h00, 8'hFF);
		end_stream();

		// sparse map, left trigger unmapped, threshold at the top
		load_config(48'h01FF_0080_7F00, 48'h0, 48'hFF00_FF00_FF00, 18'h15555, '1, '0, 8'd255);
		send_poll(3'd2, 16'hFFFF, 8'hFF, 8'hFF);
		send_poll(3'd2, 16'h0000, 8'hFF, 8'h00);
		send_poll(3'd1, 16'h5A5A, 8'd200, 8'd200);
		send_poll(3'd3, 16'hFFFF, 8'h00, 8'h00);
		end_stream();

		// trigger exactly at and one above the threshold
		load_config(48'h0102_0304_0506, 48'h0708_090A_0B0C, 48'h0D0E_0F10_1112,
			18'h0F0F0, 18'h33333, 18'h3C3C3, 8'd100);
		send_poll(3'd1, 16'h0000, 8'd100, 8'd101);
		send_poll(3'd1, 16'h0000, 8'd101, 8'd100);
		send_poll(3'd1, 16'h0000, 8'd100, 8'd100);
		end_stream();

		// random part in three pacing phases
		send_idle_pct = 7;
		recv_idle_pct = 59;
		load_config(rand_codes(), rand_codes(), rand_codes(), 18'($urandom), 18'($urandom),
			18'($urandom), 8'($urandom));
		run_random_phase(RANDOM_POLLS, -1);

		send_idle_pct = 59;
		recv_idle_pct = 7;
		load_config(rand_codes(), rand_codes(), rand_codes(), 18'($urandom), 18'($urandom),
			18'($urandom), 8'($urandom));
		run_random_phase(RANDOM_POLLS, -1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_config(rand_codes(), rand_codes(), rand_codes(), 18'($urandom), 18'($urandom),
			18'($urandom), THRESHOLD_RESET);
		run_random_phase(RANDOM_POLLS, 20);

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d polls and %0d results, %0d of them key events", poll_count,
			result_count, key_event_count);
		$display("over seven register settings, three pacing phases and one long output stall");
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
